@@ rtl/cir_pkg.sv @@
package cir_pkg;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 19;
  localparam int INC_BITS       = 19;
  localparam int BLEN_BITS      = 13;
  localparam int POS_BITS       = 12;
  localparam int MU_BITS        = 16;
  localparam int HORNER_STEPS   = 4;
  localparam int STEP_BITS      = 2;
  localparam int MIN_INC_SHIFT  = 6;
  localparam int MAX_INC_SHIFT  = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_LEN = 1'd1;

  localparam logic [INC_BITS-1:0]  INC_RESET  = 19'd65536;
  localparam logic [BLEN_BITS-1:0] BLEN_RESET = 13'd512;
  localparam logic [BLEN_BITS-1:0] BLEN_MIN   = 13'd1;
  localparam logic [BLEN_BITS-1:0] BLEN_MAX   = 13'd4096;

  typedef struct packed {
    logic shift;
    logic drop;
    logic load;
    logic mul;
    logic add;
    logic emit;
  } cir_cmd_t;

  typedef struct packed {
    logic phase_lt_one;
    logic run_done;
    logic out_free;
  } cir_status_t;

endpackage

@@ rtl/cir_lane.sv @@
module cir_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  cir_pkg::cir_cmd_t             cmd,
  input  logic signed [SAMPLE_BITS-1:0] y0,
  input  logic signed [SAMPLE_BITS-1:0] y1,
  input  logic signed [SAMPLE_BITS-1:0] y2,
  input  logic signed [SAMPLE_BITS-1:0] y3,
  input  logic [cir_pkg::MU_BITS-1:0]   mu,
  output logic signed [SAMPLE_BITS-1:0] result
);
  import cir_pkg::*;

  localparam int CB = SAMPLE_BITS + 4;
  localparam int PB = SAMPLE_BITS + 21;
  localparam int HB = PB - MU_BITS;
  localparam int MB = HB + MU_BITS + 1;
  localparam logic signed [PB-1:0] HALF   = PB'(1) << MU_BITS;
  localparam logic signed [CB-1:0] SAT_HI = CB'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [CB-1:0] SAT_LO = CB'(-(1 << (SAMPLE_BITS - 1)));

  logic signed [CB-1:0] y0e, y1e, y2e, y3e;
  logic signed [CB-1:0] a0, a1, a2, a3;
  logic signed [CB-1:0] c0, c1, c2, c3;
  logic signed [PB-1:0] p;
  logic signed [HB-1:0] p_hi;
  logic [MU_BITS-1:0] p_lo;
  logic signed [MB-1:0] prod_hi;
  logic [2*MU_BITS-1:0] prod_lo;
  logic signed [PB-1:0] rnd;
  logic signed [CB-1:0] q;

  assign y0e = CB'(y0);
  assign y1e = CB'(y1);
  assign y2e = CB'(y2);
  assign y3e = CB'(y3);

  assign a0 = (y1e <<< 1) + y1e - (y2e <<< 1) - y2e + y3e - y0e;
  assign a1 = (y0e <<< 1) - (y1e <<< 2) - y1e + (y2e <<< 2) - y3e;
  assign a2 = y2e - y0e;
  assign a3 = y1e <<< 1;

  assign p_hi = p[PB-1:MU_BITS];
  assign p_lo = p[MU_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p  <= {(PB-MU_BITS)'(a0), MU_BITS'(0)};
      c0 <= '0;
      c1 <= a1;
      c2 <= a2;
      c3 <= a3;
    end else if (cmd.add) begin
      p  <= PB'(prod_hi) + PB'(prod_lo[2*MU_BITS-1:MU_BITS])
            + {(PB-MU_BITS)'(c0), MU_BITS'(0)};
      c0 <= c1;
      c1 <= c2;
      c2 <= c3;
      c3 <= '0;
    end
    if (cmd.mul) begin
      prod_hi <= p_hi * $signed({1'b0, mu});
      prod_lo <= p_lo * mu;
    end
  end

  // round half up, then floor by 2^17
  assign rnd = p + HALF;
  assign q   = rnd[PB-1:MU_BITS+1];

  always_comb begin
    priority if (q > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

@@ rtl/cir_dpath.sv @@
module cir_dpath #(
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cir_pkg::cir_cmd_t                   cmd,
  output cir_pkg::cir_status_t                status,
  input  logic signed [SAMPLE_BITS-1:0]       in_left,
  input  logic signed [SAMPLE_BITS-1:0]       in_right,
  input  logic                                in_past_end,
  input  logic                                cfg_we,
  input  logic [cir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cir_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_left,
  output logic signed [SAMPLE_BITS-1:0]       out_right,
  output logic                                out_past_end,
  output logic                                block_last,
  output logic [cir_pkg::BLEN_BITS-1:0]       good_in_block,
  output logic                                run_last
);
  import cir_pkg::*;

  localparam int PH_BITS  = FRAC_BITS + 4;
  localparam int CMP_BITS = (PH_BITS > INC_BITS) ? PH_BITS : INC_BITS;
  localparam logic [PH_BITS-1:0]  PH_ONE  = PH_BITS'(1) << FRAC_BITS;
  localparam logic [CMP_BITS-1:0] MIN_INC = CMP_BITS'(1) << (FRAC_BITS - MIN_INC_SHIFT);
  localparam logic [CMP_BITS-1:0] MAX_INC =
    (CMP_BITS'(1) << (FRAC_BITS + MAX_INC_SHIFT)) - CMP_BITS'(1);

  logic [INC_BITS-1:0]  inc_reg;
  logic [BLEN_BITS-1:0] blen_reg;
  logic signed [SAMPLE_BITS-1:0] hist_l [4];
  logic signed [SAMPLE_BITS-1:0] hist_r [4];
  logic newest_pe;
  logic [PH_BITS-1:0] phase;
  logic [POS_BITS-1:0] block_pos;
  logic [BLEN_BITS-1:0] good_tally;
  logic end_seen;
  logic [MU_BITS-1:0] mu;
  logic [MU_BITS-1:0] mu_next;

  logic [CMP_BITS-1:0] inc_wide;
  logic [CMP_BITS-1:0] inc_clamp;
  logic [PH_BITS-1:0] inc_eff;
  logic [BLEN_BITS-1:0] blen_eff;
  logic [PH_BITS-1:0] phase_sum;
  logic [BLEN_BITS-1:0] pos_inc;
  logic last;
  logic es_next;
  logic [BLEN_BITS-1:0] tally_next;
  logic signed [SAMPLE_BITS-1:0] res_l, res_r;

  assign inc_wide = CMP_BITS'(inc_reg);

  always_comb begin
    priority if (inc_wide < MIN_INC) begin
      inc_clamp = MIN_INC;
    end else if (inc_wide > MAX_INC) begin
      inc_clamp = MAX_INC;
    end else begin
      inc_clamp = inc_wide;
    end
  end

  assign inc_eff = inc_clamp[PH_BITS-1:0];

  always_comb begin
    priority if (blen_reg < BLEN_MIN) begin
      blen_eff = BLEN_MIN;
    end else if (blen_reg > BLEN_MAX) begin
      blen_eff = BLEN_MAX;
    end else begin
      blen_eff = blen_reg;
    end
  end

  generate
    if (FRAC_BITS >= MU_BITS) begin : g_mu_trunc
      assign mu_next = phase[FRAC_BITS-1 -: MU_BITS];
    end else begin : g_mu_pad
      assign mu_next = {phase[FRAC_BITS-1:0], (MU_BITS-FRAC_BITS)'(0)};
    end
  endgenerate

  assign phase_sum  = phase + inc_eff;
  assign pos_inc    = {1'b0, block_pos} + BLEN_BITS'(1);
  assign last       = pos_inc >= blen_eff;
  assign es_next    = end_seen | newest_pe;
  assign tally_next = good_tally + BLEN_BITS'(!es_next);

  assign status.phase_lt_one = phase < PH_ONE;
  assign status.run_done     = phase_sum >= PH_ONE;
  assign status.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_reg    <= INC_RESET;
      blen_reg   <= BLEN_RESET;
      for (int i = 0; i < 4; i++) begin
        hist_l[i] <= '0;
        hist_r[i] <= '0;
      end
      newest_pe  <= 1'b0;
      phase      <= '0;
      block_pos  <= '0;
      good_tally <= '0;
      end_seen   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PHASE_INC: inc_reg  <= cfg_data[INC_BITS-1:0];
          CFG_BLOCK_LEN: blen_reg <= cfg_data[BLEN_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd.shift) begin
        for (int i = 0; i < 3; i++) begin
          hist_l[i] <= hist_l[i+1];
          hist_r[i] <= hist_r[i+1];
        end
        hist_l[3] <= in_left;
        hist_r[3] <= in_right;
        newest_pe <= in_past_end;
      end
      if (cmd.drop) begin
        phase <= phase - PH_ONE;
      end else if (cmd.emit) begin
        phase <= status.run_done ? phase_sum - PH_ONE : phase_sum;
      end
      if (cmd.emit) begin
        if (last) begin
          block_pos  <= '0;
          good_tally <= '0;
          end_seen   <= 1'b0;
        end else begin
          block_pos  <= pos_inc[POS_BITS-1:0];
          good_tally <= tally_next;
          end_seen   <= es_next;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mu <= mu_next;
    end
    if (cmd.emit) begin
      out_left      <= res_l;
      out_right     <= res_r;
      out_past_end  <= newest_pe;
      block_last    <= last;
      good_in_block <= last ? tally_next : '0;
      run_last      <= status.run_done;
    end
  end

  cir_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_left (
    .clk    (clk),
    .cmd    (cmd),
    .y0     (hist_l[0]),
    .y1     (hist_l[1]),
    .y2     (hist_l[2]),
    .y3     (hist_l[3]),
    .mu     (mu),
    .result (res_l)
  );

  cir_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_right (
    .clk    (clk),
    .cmd    (cmd),
    .y0     (hist_r[0]),
    .y1     (hist_r[1]),
    .y2     (hist_r[2]),
    .y3     (hist_r[3]),
    .mu     (mu),
    .result (res_r)
  );

endmodule

@@ rtl/cir_ctrl.sv @@
module cir_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cir_pkg::cir_status_t status,
  output cir_pkg::cir_cmd_t    cmd
);
  import cir_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state, state_next;
  logic [STEP_BITS-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.shift = 1'b1;
          if (status.phase_lt_one) begin
            state_next = ST_LOAD;
          end else begin
            cmd.drop = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        step_next  = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (step == STEP_BITS'(HORNER_STEPS - 1)) begin
          state_next = ST_FIN;
        end else begin
          step_next  = step + STEP_BITS'(1);
          state_next = ST_MUL;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.run_done ? ST_IDLE : ST_LOAD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

@@ rtl/cubic_interp_resampler_core.sv @@
// Stereo cubic resampler. A source frame is taken when the block is idle and shifted
// into a four-frame history; the frame then yields one output frame for every phase position below
// one, stepping the phase by phase_increment (clamped to 1/64 .. 8 - 2^-FRAC_BITS). Each output
// frame takes a coefficient load, four multiply and accumulate passes, each a multiply then an add,
// through the per-channel Horner unit (one 16-bit mu multiply per pass, split in two partial
// products), and the write into the output register, made once the output is free. A source
// frame yields at most 64 results; one with none is only shifted in. A finished frame waits in the
// output register, so the next source frame is taken while it is still stalled. block_last marks
// the end of every block_length output frames and carries good_in_block, the count of frames of
// that block before the first past-end frame; run_last marks the final result of a source frame.
// Configuration writes are always ready and are to be made only while the block is idle.
module cubic_interp_resampler_core #(
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_left,
  input  logic signed [SAMPLE_BITS-1:0]       in_right,
  input  logic                                in_past_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       out_left,
  output logic signed [SAMPLE_BITS-1:0]       out_right,
  output logic                                out_past_end,
  output logic                                block_last,
  output logic [cir_pkg::BLEN_BITS-1:0]       good_in_block,
  output logic                                run_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cir_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cir_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import cir_pkg::*;

  cir_cmd_t    cmd;
  cir_status_t status;

  assign cfg_ready = 1'b1;

  cir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cir_dpath #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_left       (in_left),
    .in_right      (in_right),
    .in_past_end   (in_past_end),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left      (out_left),
    .out_right     (out_right),
    .out_past_end  (out_past_end),
    .block_last    (block_last),
    .good_in_block (good_in_block),
    .run_last      (run_last)
  );

endmodule

@@ rtl/cir_checker.sv @@
module cir_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_left,
  input logic signed [SAMPLE_BITS-1:0] out_right,
  input logic                          block_last,
  input logic [cir_pkg::BLEN_BITS-1:0] good_in_block,
  input logic                          run_last
);
  import cir_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_good_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !block_last |-> good_in_block == '0)
    else $error("good count outside block end");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |-> in_stall)
    else $error("new frame taken before run finished");

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_left) && $stable(out_right)
      && $stable(run_last))
    else $error("stalled beat changed");

endmodule

bind cubic_interp_resampler_core cir_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_cir_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_left      (out_left),
  .out_right     (out_right),
  .block_last    (block_last),
  .good_in_block (good_in_block),
  .run_last      (run_last)
);
